// File: design/acp_pkg.sv
// Shared constants, codes and types for the ASAP column packer.
package acp_pkg;

	// Geometry
	localparam int MAX_QUBITS   = 32;
	localparam int COLUMN_BITS  = 16;
	localparam int ROWS         = MAX_QUBITS + 1;
	localparam int CLS_ROW      = MAX_QUBITS;
	localparam int MASK_BITS    = 32;
	localparam int QCOUNT_BITS  = 6;
	localparam int TREE_LEVELS  = $clog2(ROWS);
	localparam int TREE_LEAVES  = 2 ** TREE_LEVELS;
	localparam int SMEAR_STEPS  = $clog2(MAX_QUBITS);

	localparam logic [COLUMN_BITS-1:0] CURSOR_MAX = '1;
	localparam logic [QCOUNT_BITS-1:0] QCOUNT_MAX = QCOUNT_BITS'(MAX_QUBITS);
	localparam logic [QCOUNT_BITS-1:0] QCOUNT_RST = QCOUNT_BITS'(32);

	// Stream field widths
	localparam int S_TDATA_BITS = MASK_BITS;
	localparam int S_TUSER_BITS = 4;
	localparam int M_TDATA_BITS = COLUMN_BITS;

	// Configuration port
	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_DATA_BITS = QCOUNT_BITS;
	localparam logic [CFG_IDX_BITS-1:0] REG_QUBIT_COUNT = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_CLS_ENABLE  = 1'b1;

	// Operation codes
	localparam logic OP_PLACE = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	// Gate kinds (code 3 behaves as plain)
	localparam logic [1:0] KIND_PLAIN    = 2'd0;
	localparam logic [1:0] KIND_SPANNING = 2'd1;
	localparam logic [1:0] KIND_BARRIER  = 2'd2;

	typedef logic [COLUMN_BITS-1:0] column_t;

	// Rows a gate touches
	typedef struct packed {
		logic [MAX_QUBITS-1:0] qubits;
		logic                  classical;
	} acp_touch_t;

endpackage

// File: design/acp_row_select.sv
// Touched-row decode: qubit rows and the classical row hit by one gate.
module acp_row_select (
	input  logic [1:0]                      gate_kind,
	input  logic [acp_pkg::MASK_BITS-1:0]   qubit_mask,
	input  logic                            is_conditional,
	input  logic [acp_pkg::QCOUNT_BITS-1:0] qubit_count,
	input  logic                            cls_enable,
	output acp_pkg::acp_touch_t             touch
);
	import acp_pkg::*;

	logic [QCOUNT_BITS-1:0] rows_used;
	logic [MAX_QUBITS-1:0]  use_mask;
	logic [MAX_QUBITS-1:0]  named;
	logic [MAX_QUBITS-1:0]  fill_up;
	logic [MAX_QUBITS-1:0]  fill_dn;

	// Clamp row count, build in-use mask
	always_comb begin
		rows_used = (qubit_count > QCOUNT_MAX) ? QCOUNT_MAX : qubit_count;
		for (int r = 0; r < MAX_QUBITS; r++) begin
			use_mask[r] = (QCOUNT_BITS'(r) < rows_used);
		end
		named = qubit_mask[MAX_QUBITS-1:0] & use_mask;
	end

	// Span fill: smear named bits up and down, overlap is lowest..highest
	always_comb begin
		fill_up = named;
		fill_dn = named;
		for (int s = 0; s < SMEAR_STEPS; s++) begin
			fill_up = fill_up | (fill_up << (2 ** s));
			fill_dn = fill_dn | (fill_dn >> (2 ** s));
		end
	end

	// Select by gate kind
	always_comb begin
		case (gate_kind)
			KIND_BARRIER: begin
				touch.qubits    = use_mask;
				touch.classical = cls_enable;
			end
			KIND_SPANNING: begin
				touch.qubits    = fill_up & fill_dn;
				touch.classical = 1'b0;
			end
			default: begin
				touch.qubits    = named;
				touch.classical = is_conditional & cls_enable;
			end
		endcase
	end

endmodule

// File: design/asap_column_packer_core.sv
// Top level of the ASAP column packer: stream ports, cursors, max and update.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------
//  s       | in  | s_tvalid/s_tready  | tdata: qubit_mask; tuser: op, kind, cond
//  m       | out | m_tvalid/m_tready  | tdata: column
//  cfg     | in  | cfg_we             | cfg_index, cfg_wdata
//
// One gate per cycle sustained while the result side keeps m_tready high. A result
// is registered first in the input register, then in the result register.
// The 33-row max tree and cursor update sit between those two registers, so each
// gate sees the cursors the previous one left. Reset clears cursors, both valid
// flags and the classical enable, and sets the qubit count to 32. A stalled result
// holds the pipe; the input register still takes one item.
module asap_column_packer_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [acp_pkg::S_TDATA_BITS-1:0]    s_tdata,   // [31:0] qubit_mask
	input  logic [acp_pkg::S_TUSER_BITS-1:0]    s_tuser,   // [0] operation, [2:1] gate_kind,
	                                                       // [3] is_conditional
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [acp_pkg::M_TDATA_BITS-1:0]    m_tdata,   // [15:0] column
	input  logic                                cfg_we,
	input  logic [acp_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [acp_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
	import acp_pkg::*;

	// Configuration
	logic [QCOUNT_BITS-1:0] qcount_q;
	logic                   cls_en_q;

	// Input register
	logic                   valid_s1;
	logic                   op_s1;
	logic [1:0]             kind_s1;
	logic [MASK_BITS-1:0]   mask_s1;
	logic                   cond_s1;

	// Cursors and result register
	column_t                cursor_q [ROWS];
	logic                   out_valid_q;
	column_t                column_q;

	acp_touch_t             touch;
	logic [ROWS-1:0]        hit;
	column_t                tree [TREE_LEVELS+1][TREE_LEAVES];
	column_t                col_max;
	column_t                col_next;
	logic                   advance;

	assign advance  = valid_s1 & (~out_valid_q | m_tready);
	assign s_tready = ~valid_s1 | ~out_valid_q | m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = column_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qcount_q <= QCOUNT_RST;
			cls_en_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_QUBIT_COUNT: qcount_q <= cfg_wdata;
				REG_CLS_ENABLE:  cls_en_q <= cfg_wdata[0];
				default:         ;
			endcase
		end
	end

	// Input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= s_tuser[0];
			kind_s1 <= s_tuser[2:1];
			cond_s1 <= s_tuser[3];
			mask_s1 <= s_tdata[MASK_BITS-1:0];
		end
	end

	acp_row_select u_rows (
		.gate_kind      (kind_s1),
		.qubit_mask     (mask_s1),
		.is_conditional (cond_s1),
		.qubit_count    (qcount_q),
		.cls_enable     (cls_en_q),
		.touch          (touch)
	);

	assign hit = {touch.classical, touch.qubits};

	// Max tree over the touched cursors (untouched rows count as zero)
	always_comb begin
		for (int i = 0; i < TREE_LEAVES; i++) begin
			tree[0][i] = '0;
		end
		for (int i = 0; i < ROWS; i++) begin
			tree[0][i] = hit[i] ? cursor_q[i] : '0;
		end
		for (int l = 0; l < TREE_LEVELS; l++) begin
			for (int i = 0; i < TREE_LEAVES; i++) begin
				tree[l+1][i] = '0;
			end
			for (int i = 0; i < (TREE_LEAVES >> (l + 1)); i++) begin
				tree[l+1][i] = (tree[l][2*i] > tree[l][2*i+1]) ? tree[l][2*i]
				                                                 : tree[l][2*i+1];
			end
		end
		col_max  = tree[TREE_LEVELS][0];
		col_next = (col_max == CURSOR_MAX) ? col_max : col_max + COLUMN_BITS'(1);
	end

	// Cursor update: clear all, or touched rows take column+1, held at the top column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ROWS; i++) begin
				cursor_q[i] <= '0;
			end
		end else if (advance) begin
			for (int i = 0; i < ROWS; i++) begin
				if (op_s1 == OP_CLEAR) begin
					cursor_q[i] <= '0;
				end else if (hit[i]) begin
					cursor_q[i] <= col_next;
				end
			end
		end
	end

	// Result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (advance) begin
			column_q <= (op_s1 == OP_CLEAR) ? '0 : col_max;
		end
	end

endmodule

// File: design/acp_checker.sv
// Port-level checks for the ASAP column packer, bound to the top level.
module acp_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic [acp_pkg::S_TUSER_BITS-1:0]  s_tuser,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [acp_pkg::M_TDATA_BITS-1:0]  m_tdata
);
	import acp_pkg::*;

	logic s_xfer;
	assign s_xfer = s_tvalid & s_tready;

	// A stalled result keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Input backpressure only when both stages are full and the sink stalls
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without a full pipe");

	// No result appears without an earlier transfer or a held item
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid && $past(!m_tvalid) && !s_xfer && $past(!s_xfer) |=> !m_tvalid)
		else $error("result with no item behind it");

	// A clear drives column zero when the pipe is empty behind it
	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		s_xfer && s_tuser[0] == OP_CLEAR && !m_tvalid && $past(!s_xfer)
		|=> ##1 m_tvalid && m_tdata == '0)
		else $error("clear did not return column zero");

endmodule

bind asap_column_packer_core acp_checker u_acp_checker (.*);

// File: verif/testbench.sv
// Self-checking testbench for the ASAP column packer core.
module testbench;
	import acp_pkg::*;

	localparam int          LIMIT_CYCLES = 800_000;
	localparam int          PHASE_ITEMS  = 175;
	localparam int          FILL_ITEMS   = 8;
	localparam logic [1:0]  KIND_UNUSED  = 2'd3;

	// One input transfer, as the predictor sees it
	typedef struct packed {
		logic                 cond;
		logic [1:0]           kind;
		logic                 op;
		logic [MASK_BITS-1:0] mask;
	} gate_t;

	// Column predictor and the queue of columns still to come out
	class column_scoreboard;
		column_t     cursor[ROWS];
		int unsigned qubit_count;
		bit          cls_enable;
		column_t     expected_col[$];
		int          errors;

		function void reset_state();
			foreach (cursor[r]) cursor[r] = '0;
			qubit_count = 32;
			cls_enable  = 1'b0;
			expected_col.delete();
			errors = 0;
		endfunction

		function void write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int value);
			if (idx == REG_QUBIT_COUNT)
				qubit_count = value & 63;
			else
				cls_enable = value[0];
		endfunction

		function int pending();
			return expected_col.size();
		endfunction

		// Work out the column of one accepted gate and advance the cursors
		function void note_gate(input gate_t g);
			logic [ROWS-1:0] hit;
			int              rows;
			int              lo;
			int              hi;
			column_t         col;
			bit              any;
			hit  = '0;
			col  = '0;
			any  = 1'b0;
			lo   = -1;
			hi   = -1;
			rows = (qubit_count > MAX_QUBITS) ? MAX_QUBITS : qubit_count;
			if (g.op == OP_CLEAR) begin
				foreach (cursor[r]) cursor[r] = '0;
				expected_col = {expected_col, col};
				return;
			end
			for (int r = 0; r < rows; r++)
				hit[r] = g.mask[r];
			case (g.kind)
				KIND_BARRIER: begin
					for (int r = 0; r < rows; r++)
						hit[r] = 1'b1;
					hit[CLS_ROW] = cls_enable;
				end
				KIND_SPANNING: begin
					for (int r = 0; r < rows; r++) begin
						if (hit[r]) begin
							if (lo < 0)
								lo = r;
							hi = r;
						end
					end
					if (lo >= 0)
						for (int r = lo; r <= hi; r++)
							hit[r] = 1'b1;
				end
				default: begin
					hit[CLS_ROW] = g.cond && cls_enable;
				end
			endcase
			for (int r = 0; r < ROWS; r++) begin
				if (hit[r]) begin
					any = 1'b1;
					if (cursor[r] > col)
						col = cursor[r];
				end
			end
			// touched rows move past the gate, stopping at the top column
			if (any)
				for (int r = 0; r < ROWS; r++)
					if (hit[r])
						cursor[r] = (col == CURSOR_MAX) ? CURSOR_MAX : col + 1'b1;
			expected_col = {expected_col, col};
		endfunction

		function void check_column(input column_t got);
			column_t want;
			if (expected_col.size() == 0) begin
				$display("%0t: column transfer with none expected, expected none, got %0d",
					$time, got);
				errors++;
				return;
			end
			want = expected_col.pop_front();
			if (got !== want) begin
				$display("%0t: column mismatch, expected %0d, got %0d", $time, want, got);
				errors++;
			end
		endfunction
	endclass

	logic                      clk;
	logic                      arst_n;
	logic                      s_tvalid;
	logic                      s_tready;
	logic [S_TDATA_BITS-1:0]   s_tdata;
	logic [S_TUSER_BITS-1:0]   s_tuser;
	logic                      m_tvalid;
	logic                      m_tready;
	logic [M_TDATA_BITS-1:0]   m_tdata;
	logic                      cfg_we;
	logic [CFG_IDX_BITS-1:0]   cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_wdata;

	column_scoreboard sb;
	bit               idle_on;
	int               cycle_count = 0;

	asap_column_packer_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Send one gate; valid stays high after the transfer for the caller to reuse
	task automatic send_gate(input gate_t g);
		int gap;
		gap = idle_on ? $urandom_range(0, 13) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= g.mask;
		s_tuser  <= {g.cond, g.kind, g.op};
		do @(posedge clk); while (!s_tready);
		sb.note_gate(g);
	endtask

	task automatic place(input logic op, input logic [1:0] kind,
			input logic [MASK_BITS-1:0] mask, input logic cond);
		gate_t g;
		g.op   = op;
		g.kind = kind;
		g.mask = mask;
		g.cond = cond;
		send_gate(g);
	endtask

	// Drain the pipe before touching the registers
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int value);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CFG_DATA_BITS'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, value);
	endtask

	// Random gate; masks lean toward rows in use so columns build up
	function automatic gate_t random_gate(input int unsigned rows);
		gate_t                g;
		int                   pick;
		logic [MASK_BITS-1:0] in_use;
		in_use = (rows >= MASK_BITS) ? '1 : ((MASK_BITS'(1) << rows) - 1'b1);
		g.op   = ($urandom_range(0, 99) < 2) ? OP_CLEAR : OP_PLACE;
		pick   = $urandom_range(0, 19);
		g.kind = (pick < 9) ? KIND_PLAIN : (pick < 14) ? KIND_SPANNING :
			(pick < 17) ? KIND_BARRIER : KIND_UNUSED;
		g.cond = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 6))
			0:       g.mask = MASK_BITS'(1) << $urandom_range(0, 31);
			1:       g.mask = (MASK_BITS'(1) << $urandom_range(0, 31)) |
				(MASK_BITS'(1) << $urandom_range(0, 31));
			2:       g.mask = $urandom & $urandom & in_use;
			3:       g.mask = $urandom & in_use;
			4:       g.mask = $urandom;
			5:       g.mask = $urandom & $urandom & $urandom;
			default: g.mask = $urandom_range(0, 1) ? '1 : '0;
		endcase
		return g;
	endfunction

	// Result side with random stalls
	initial begin : result_sink
		int stall;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = idle_on ? $urandom_range(0, 13) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_column(m_tdata);
		end
	end

	// Stimulus and end of run
	initial begin : stimulus
		int count_plan[11];
		sb = new;
		sb.reset_state();
		idle_on     = 1'b1;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_QUBIT_COUNT;
		cfg_wdata <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset settings, classical row off
		place(OP_PLACE, KIND_PLAIN,    32'h0000_0000, 1'b0);
		place(OP_PLACE, KIND_PLAIN,    32'hFFFF_FFFF, 1'b1);
		place(OP_PLACE, KIND_PLAIN,    32'h8000_0000, 1'b0);
		place(OP_PLACE, KIND_SPANNING, 32'h0001_0004, 1'b0);
		place(OP_PLACE, KIND_SPANNING, 32'h0000_0020, 1'b1);
		place(OP_PLACE, KIND_SPANNING, 32'h0000_0000, 1'b0);
		place(OP_PLACE, KIND_BARRIER,  32'h0000_0000, 1'b0);
		place(OP_PLACE, KIND_UNUSED,   32'h0000_0080, 1'b1);
		place(OP_PLACE, KIND_PLAIN,    32'h0000_0000, 1'b1);
		place(OP_CLEAR, KIND_BARRIER,  32'hFFFF_FFFF, 1'b1);
		place(OP_PLACE, KIND_PLAIN,    32'h0000_0001, 1'b0);

		// Classical row on
		write_reg(REG_CLS_ENABLE, 1);
		place(OP_PLACE, KIND_PLAIN,    32'h0000_0000, 1'b1);
		place(OP_PLACE, KIND_PLAIN,    32'h0000_0008, 1'b1);
		place(OP_PLACE, KIND_SPANNING, 32'h8000_0001, 1'b1);
		place(OP_PLACE, KIND_BARRIER,  32'h0000_0000, 1'b0);
		place(OP_PLACE, KIND_UNUSED,   32'h0000_0200, 1'b1);

		// Few rows in use, cursors of upper rows kept
		write_reg(REG_QUBIT_COUNT, 3);
		place(OP_PLACE, KIND_PLAIN,    32'hFFFF_FFF8, 1'b0);
		place(OP_PLACE, KIND_SPANNING, 32'h8000_0001, 1'b0);
		place(OP_PLACE, KIND_BARRIER,  32'h0000_0000, 1'b0);

		// No qubit rows
		write_reg(REG_QUBIT_COUNT, 0);
		place(OP_PLACE, KIND_BARRIER,  32'h0000_0000, 1'b0);
		place(OP_PLACE, KIND_PLAIN,    32'hFFFF_FFFF, 1'b0);

		// Oversized row count, classical row off again
		write_reg(REG_QUBIT_COUNT, 63);
		write_reg(REG_CLS_ENABLE, 0);
		place(OP_PLACE, KIND_BARRIER,  32'h0000_0000, 1'b1);
		place(OP_PLACE, KIND_PLAIN,    32'h8000_0000, 1'b0);
		place(OP_CLEAR, KIND_PLAIN,    32'h0000_0000, 1'b0);

		// Random phases across register settings, mostly without clearing
		count_plan = '{32, 1, 0, 63, 33, 17, 5, 2, 31, 8, 32};
		count_plan[10] = $urandom_range(1, 32);
		for (int p = 0; p < 11; p++) begin
			write_reg(REG_QUBIT_COUNT, count_plan[p]);
			write_reg(REG_CLS_ENABLE, p % 2);
			idle_on = (p % 4 != 3);
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_gate(random_gate(sb.qubit_count));
		end

		// Run one row back to back at full rate
		write_reg(REG_QUBIT_COUNT, 1);
		write_reg(REG_CLS_ENABLE, 1);
		idle_on = 1'b0;
		for (int i = 0; i < FILL_ITEMS; i++)
			place(OP_PLACE, KIND_PLAIN, 32'h0000_0001, 1'b0);
		place(OP_PLACE, KIND_PLAIN,   32'h0000_0000, 1'b1);
		place(OP_PLACE, KIND_BARRIER, 32'h0000_0000, 1'b0);
		place(OP_PLACE, KIND_PLAIN,   32'h0000_0001, 1'b1);
		idle_on = 1'b1;
		place(OP_CLEAR, KIND_PLAIN,   32'h0000_0000, 1'b0);
		place(OP_PLACE, KIND_PLAIN,   32'h0000_0001, 1'b1);

		settle();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: sim.f
design/acp_pkg.sv
design/acp_row_select.sv
design/asap_column_packer_core.sv
design/acp_checker.sv
verif/testbench.sv
